FILE: rtl/lbc_pkg.sv
package lbc_pkg;

    localparam int LBC_NUM_ENTRIES = 64;
    localparam int LBC_TIME_WIDTH  = 40;

    localparam int KEY_W      = 49;
    localparam int SIZE_W     = 32;
    localparam int BYTES_W    = 44;
    localparam int CNT_W      = 7;
    localparam int TOTAL_W    = 32;
    localparam int BUDGET_W   = 12;
    localparam int MEBI_SHIFT = 20;

    localparam logic [BUDGET_W-1:0] BUDGET_RST = 12'd256;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_PUT    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_CLREXP = 3'd3,
        OP_CLRALL = 3'd4,
        OP_STATS  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_HIT  = 2'd0,
        ST_MISS = 2'd1,
        ST_DONE = 2'd2
    } status_t;

endpackage

FILE: rtl/lbc_ram.sv
module lbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/lru_byte_budget_tag_cache.sv
// Every operation walks the entry table one slot per cycle. Get and remove take one
// or two walks, clear expired two walks per expired entry plus one, put up to
// 2 * evictions + 3 walks. Clear all and statistics reset take no walk. One item
// is in work at a time.
// Reset (aresetn low, synchronous) empties the table, zeroes the byte and hit/miss
// totals and sets the budget to 256 MiB; no clearing pass is needed.
module lru_byte_budget_tag_cache import lbc_pkg::*; #(
    parameter int NUM_ENTRIES = LBC_NUM_ENTRIES,
    parameter int TIME_WIDTH  = LBC_TIME_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [BUDGET_W-1:0]   cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [2:0]            s_opcode,
    input  logic [KEY_W-1:0]      s_tile_key,
    input  logic [SIZE_W-1:0]     s_tile_bytes,
    input  logic [TIME_WIDTH-1:0] s_expiry_time,
    input  logic [TIME_WIDTH-1:0] s_now_time,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic [CNT_W-1:0]      m_removed_count,
    output logic [CNT_W-1:0]      m_evicted_count,
    output logic [BYTES_W-1:0]    m_bytes_in_use,
    output logic [CNT_W-1:0]      m_entries_in_use,
    output logic [TOTAL_W-1:0]    m_hit_total,
    output logic [TOTAL_W-1:0]    m_miss_total
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam int MW = KEY_W + SIZE_W + TIME_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_PBUD, S_PCAP, S_SCAN, S_DROP, S_INSERT, S_DONE
    } state_t;
    typedef enum logic [2:0] {M_FKEY, M_FAGE, M_FEXP, M_TOUCH, M_DEC, M_INC} mode_t;
    typedef enum logic [1:0] {C_KEY, C_EXP, C_BUDGET, C_CAP} cause_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, l_mode;
    cause_t cause_reg, l_cause;
    logic   launch;

    logic [2:0]            op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [TIME_WIDTH-1:0] exp_reg;
    logic [TIME_WIDTH-1:0] now_reg;

    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [CW-1:0]          count_reg;
    logic [BYTES_W-1:0]     bytes_reg;
    logic [TOTAL_W-1:0]     hit_reg;
    logic [TOTAL_W-1:0]     miss_reg;
    logic [BUDGET_W-1:0]    budget_reg;
    logic                   over_reg;

    logic [AW:0]           iss_reg;
    logic                  rd_v_reg;
    logic [AW-1:0]         rd_idx_reg;
    logic                  end_reg;
    logic                  found_reg;
    logic [AW-1:0]         slot_reg;
    logic [AW-1:0]         fage_reg;
    logic [SIZE_W-1:0]     fsize_reg;
    logic [TIME_WIDTH-1:0] fexp_reg;
    logic                  free_found_reg;
    logic [AW-1:0]         free_reg;
    logic [AW-1:0]         target_reg;
    logic [CW-1:0]         removed_reg;
    logic [CW-1:0]         evicted_reg;
    status_t               status_reg;

    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [CNT_W-1:0]      m_removed_reg;
    logic [CNT_W-1:0]      m_evicted_reg;
    logic [BYTES_W-1:0]    m_bytes_reg;
    logic [CNT_W-1:0]      m_entries_reg;
    logic [TOTAL_W-1:0]    m_hit_reg;
    logic [TOTAL_W-1:0]    m_miss_reg;

    logic [MW-1:0]         main_rd;
    logic [AW-1:0]         age_rd;
    logic                  age_we;
    logic [AW-1:0]         age_wd;
    logic [AW-1:0]         age_waddr;
    logic [KEY_W-1:0]      rd_key;
    logic [SIZE_W-1:0]     rd_size;
    logic [TIME_WIDTH-1:0] rd_exp;
    logic                  rd_valid;
    logic                  rd_expired;
    logic                  f_expired;
    logic                  match;
    logic                  hit_now;
    logic                  issuing;
    logic                  full;
    logic                  bud_evict;
    logic [BYTES_W:0]      need;
    logic [BYTES_W:0]      limit;
    logic [BYTES_W-1:0]    half;

    lbc_ram #(.WIDTH(MW), .DEPTH(NUM_ENTRIES)) u_main_ram (
        .aclk    (aclk),
        .wr_en   (state_reg == S_INSERT),
        .wr_addr (free_reg),
        .wr_data ({key_reg, size_reg, exp_reg}),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_data (main_rd)
    );

    lbc_ram #(.WIDTH(AW), .DEPTH(NUM_ENTRIES)) u_age_ram (
        .aclk    (aclk),
        .wr_en   (age_we),
        .wr_addr (age_waddr),
        .wr_data (age_wd),
        .rd_addr (iss_reg[AW-1:0]),
        .rd_data (age_rd)
    );

    assign rd_key     = main_rd[MW-1 -: KEY_W];
    assign rd_size    = main_rd[TIME_WIDTH +: SIZE_W];
    assign rd_exp     = main_rd[TIME_WIDTH-1:0];
    assign rd_valid   = valid_reg[rd_idx_reg];
    assign rd_expired = (rd_exp != '0) && (now_reg > rd_exp);
    assign f_expired  = (fexp_reg != '0) && (now_reg > fexp_reg);
    assign issuing    = (state_reg == S_SCAN) && (iss_reg < (AW+1)'(NUM_ENTRIES));
    assign full       = (count_reg == CW'(NUM_ENTRIES));

    // The byte limit is budget_reg mebibytes; the eviction target is half of it.
    assign limit     = (BYTES_W+1)'({budget_reg, MEBI_SHIFT'(0)});
    assign half      = BYTES_W'({budget_reg, (MEBI_SHIFT-1)'(0)});
    assign need      = (BYTES_W+1)'(bytes_reg) + (BYTES_W+1)'(size_reg);
    assign bud_evict = over_reg && (bytes_reg > half) && (count_reg != '0);

    always_comb begin
        unique case (mode_reg)
            M_FKEY:  match = (rd_key == key_reg);
            M_FAGE:  match = (age_rd == target_reg);
            M_FEXP:  match = rd_expired;
            default: match = 1'b0;
        endcase
    end

    assign hit_now = (state_reg == S_SCAN) && rd_v_reg && rd_valid && match && !found_reg;

    // Age updates of a walk read-modify-write the slot whose data arrives this cycle.
    always_comb begin
        age_we    = 1'b0;
        age_wd    = age_rd;
        age_waddr = rd_idx_reg;
        if (state_reg == S_INSERT) begin
            age_we    = 1'b1;
            age_wd    = '0;
            age_waddr = free_reg;
        end else if (state_reg == S_SCAN && rd_v_reg && rd_valid) begin
            unique case (mode_reg)
                M_TOUCH: begin
                    if (rd_idx_reg == slot_reg) begin
                        age_we = 1'b1;
                        age_wd = '0;
                    end else if (age_rd < fage_reg) begin
                        age_we = 1'b1;
                        age_wd = age_rd + 1'b1;
                    end
                end
                M_DEC: begin
                    if (age_rd > fage_reg) begin
                        age_we = 1'b1;
                        age_wd = age_rd - 1'b1;
                    end
                end
                M_INC: begin
                    age_we = 1'b1;
                    age_wd = age_rd + 1'b1;
                end
                default: age_we = 1'b0;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        launch     = 1'b0;
        l_mode     = M_FKEY;
        l_cause    = cause_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                unique case (op_reg)
                    OP_GET, OP_REMOVE: begin
                        launch  = 1'b1;
                        l_mode  = M_FKEY;
                        l_cause = C_KEY;
                    end
                    OP_PUT: state_next = S_PBUD;
                    OP_CLREXP: begin
                        launch  = 1'b1;
                        l_mode  = M_FEXP;
                        l_cause = C_EXP;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_PBUD: begin
                launch = 1'b1;
                if (bud_evict) begin
                    l_mode  = M_FAGE;
                    l_cause = C_BUDGET;
                end else begin
                    l_mode  = M_FKEY;
                    l_cause = C_KEY;
                end
            end
            S_PCAP: begin
                launch  = 1'b1;
                l_cause = C_CAP;
                l_mode  = full ? M_FAGE : M_INC;
            end
            S_SCAN: begin
                if (end_reg) begin
                    unique case (mode_reg)
                        M_FKEY, M_FAGE, M_FEXP: begin
                            if (found_reg) begin
                                if (mode_reg == M_FKEY && op_reg == OP_GET) begin
                                    if (!f_expired) begin
                                        launch = 1'b1;
                                        l_mode = M_TOUCH;
                                    end else begin
                                        state_next = S_DONE;
                                    end
                                end else begin
                                    state_next = S_DROP;
                                end
                            end else begin
                                unique case (cause_reg)
                                    C_KEY: state_next = (op_reg == OP_PUT) ? S_PCAP : S_DONE;
                                    C_EXP: state_next = S_DONE;
                                    C_BUDGET: state_next = S_PCAP;
                                    C_CAP: begin
                                        launch = 1'b1;
                                        l_mode = M_INC;
                                    end
                                endcase
                            end
                        end
                        M_TOUCH: state_next = S_DONE;
                        M_DEC: begin
                            unique case (cause_reg)
                                C_KEY: state_next = (op_reg == OP_PUT) ? S_PCAP : S_DONE;
                                C_EXP: begin
                                    launch = 1'b1;
                                    l_mode = M_FEXP;
                                end
                                C_BUDGET: state_next = S_PBUD;
                                C_CAP: begin
                                    launch = 1'b1;
                                    l_mode = M_INC;
                                end
                            endcase
                        end
                        M_INC: state_next = S_INSERT;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_DROP: begin
                launch = 1'b1;
                l_mode = M_DEC;
            end
            S_INSERT: state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (launch) begin
            state_next = S_SCAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mode_reg       <= M_FKEY;
            cause_reg      <= C_KEY;
            valid_reg      <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            hit_reg        <= '0;
            miss_reg       <= '0;
            budget_reg     <= BUDGET_RST;
            m_valid_reg    <= 1'b0;
            rd_v_reg       <= 1'b0;
            end_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            iss_reg        <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                budget_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end

            if (launch) begin
                mode_reg       <= l_mode;
                cause_reg      <= l_cause;
                iss_reg        <= '0;
                rd_v_reg       <= 1'b0;
                end_reg        <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else begin
                rd_v_reg <= issuing;
                if (issuing) begin
                    iss_reg    <= iss_reg + 1'b1;
                    rd_idx_reg <= iss_reg[AW-1:0];
                end
                if (state_reg == S_SCAN && rd_v_reg
                        && rd_idx_reg == AW'(NUM_ENTRIES - 1)) begin
                    end_reg <= 1'b1;
                end
                if (hit_now) begin
                    found_reg <= 1'b1;
                    slot_reg  <= rd_idx_reg;
                    fage_reg  <= age_rd;
                    fsize_reg <= rd_size;
                    fexp_reg  <= rd_exp;
                end
                // The insert walk also picks the lowest-numbered free slot.
                if (state_reg == S_SCAN && mode_reg == M_INC && rd_v_reg && !rd_valid
                        && !free_found_reg) begin
                    free_found_reg <= 1'b1;
                    free_reg       <= rd_idx_reg;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg      <= s_opcode;
                        key_reg     <= s_tile_key;
                        size_reg    <= s_tile_bytes;
                        exp_reg     <= s_expiry_time;
                        now_reg     <= s_now_time;
                        removed_reg <= '0;
                        evicted_reg <= '0;
                        status_reg  <= ST_DONE;
                    end
                end
                S_START: begin
                    if (op_reg == OP_CLRALL) begin
                        removed_reg <= count_reg;
                        valid_reg   <= '0;
                        count_reg   <= '0;
                        bytes_reg   <= '0;
                    end
                    if (op_reg == OP_STATS) begin
                        hit_reg  <= '0;
                        miss_reg <= '0;
                    end
                    over_reg <= (need > limit);
                end
                S_PBUD: begin
                    target_reg <= AW'(count_reg - 1'b1);
                end
                S_PCAP: begin
                    target_reg <= AW'(count_reg - 1'b1);
                end
                S_SCAN: begin
                    if (end_reg && mode_reg == M_FKEY && op_reg == OP_GET) begin
                        if (found_reg && !f_expired) begin
                            status_reg <= ST_HIT;
                            if (hit_reg != TOTAL_MAX) begin
                                hit_reg <= hit_reg + 1'b1;
                            end
                        end else begin
                            status_reg <= ST_MISS;
                            if (miss_reg != TOTAL_MAX) begin
                                miss_reg <= miss_reg + 1'b1;
                            end
                        end
                    end
                end
                S_DROP: begin
                    valid_reg[slot_reg] <= 1'b0;
                    count_reg           <= count_reg - 1'b1;
                    if (bytes_reg >= BYTES_W'(fsize_reg)) begin
                        bytes_reg <= bytes_reg - BYTES_W'(fsize_reg);
                    end else begin
                        bytes_reg <= '0;
                    end
                    unique case (cause_reg)
                        C_KEY: begin
                            if (op_reg == OP_REMOVE) begin
                                removed_reg <= CW'(1);
                            end
                        end
                        C_EXP: removed_reg <= removed_reg + 1'b1;
                        C_BUDGET, C_CAP: evicted_reg <= evicted_reg + 1'b1;
                    endcase
                end
                S_INSERT: begin
                    valid_reg[free_reg] <= 1'b1;
                    count_reg           <= count_reg + 1'b1;
                    bytes_reg           <= bytes_reg + BYTES_W'(size_reg);
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= status_reg;
                        m_removed_reg <= CNT_W'(removed_reg);
                        m_evicted_reg <= CNT_W'(evicted_reg);
                        m_bytes_reg   <= bytes_reg;
                        m_entries_reg <= CNT_W'(count_reg);
                        m_hit_reg     <= hit_reg;
                        m_miss_reg    <= miss_reg;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_removed_count  = m_removed_reg;
    assign m_evicted_count  = m_evicted_reg;
    assign m_bytes_in_use   = m_bytes_reg;
    assign m_entries_in_use = m_entries_reg;
    assign m_hit_total      = m_hit_reg;
    assign m_miss_total     = m_miss_reg;

endmodule
